@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the propagator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication assertion failed");

// Condition that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
		else $error("invariant assertion failed");

`endif

@@ rtl/tcp_pkg.sv @@
// ----------------------------------------------------------------------------
// tcp_pkg
// Constants, codes and types shared by the propagator and its cells.
// ----------------------------------------------------------------------------
package tcp_pkg;

	localparam int NV       = 8;
	localparam int NR       = 64;
	localparam int STK      = NV * (NV + 1);
	localparam int VW       = $clog2(NV);
	localparam int RW       = $clog2(NR);
	localparam int SW       = $clog2(STK + 1);
	localparam int CW       = VW + 3;

	localparam logic [3:0] MARKER = 4'hF;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_ASSIGN = 2'd1;
	localparam logic [1:0] MODE_UNDO   = 2'd2;

	localparam logic [1:0] KIND_DONE     = 2'd0;
	localparam logic [1:0] KIND_PRUNE    = 2'd1;
	localparam logic [1:0] KIND_CONFLICT = 2'd2;

	localparam logic [1:0] CFG_NUM_SUPPORTS = 2'd0;
	localparam logic [1:0] CFG_NUM_VARS     = 2'd1;
	localparam logic [1:0] CFG_DOMAIN_SIZES = 2'd2;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_PAIR     = 8'b0000_0010,
		ST_SCAN     = 8'b0000_0100,
		ST_EVAL     = 8'b0000_1000,
		ST_EMIT     = 8'b0001_0000,
		ST_FIN      = 8'b0010_0000,
		ST_UNDO_RD  = 8'b0100_0000,
		ST_UNDO_CHK = 8'b1000_0000
	} state_t;

	// Controls broadcast to every cell.
	typedef struct packed {
		logic          wr_en;
		logic [RW-1:0] wr_row;
		logic [3:0]    wr_val;
		logic          rd_en;
		logic [RW-1:0] rd_row;
		logic          clr_scan;
		logic          upd;
		logic [2:0]    set_val;
	} cell_ctl_t;

	// Controls aimed at one cell.
	typedef struct packed {
		logic wr;
		logic set;
		logic clr;
	} cell_sel_t;

endpackage

@@ rtl/table_constraint_propagator_top.sv @@
// ----------------------------------------------------------------------------
// table_constraint_propagator_top
// Support table propagator built as a row of per-variable cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A load item writes one
// support entry and busy never rises. An assign pair passes through the pair
// state and back to idle; a last pair without a clash then scans the support
// rows one per cycle through the cell row and, if any row matches, walks all 64
// (variable, value) slots one per cycle to pick out pruned values. An undo item
// pops entries singly, via a read and a check state. Results appear on kind,
// prune_var, prune_val and last for exactly one cycle, marked by strobe; the
// receiver cannot stall them, and none are dropped. Every result of one
// assignment ends with last high. Configuration writes are taken at any time
// (cfg_ready is always high) and must only be issued while the block is idle.
// Support entries that were never loaded read back as unspecified values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_constraint_propagator_top
	import tcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [5:0]        row_index,
	input  logic [2:0]        var_index,
	input  logic signed [3:0] value,
	input  logic              last_of_literal,
	output logic              strobe,
	output logic [1:0]        kind,
	output logic [2:0]        prune_var,
	output logic [2:0]        prune_val,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data
);

	state_t        state_q;
	logic [6:0]    num_supports_q;
	logic [3:0]    num_vars_q;
	logic [23:0]   domain_sizes_q;
	logic [6:0]    nr_eff;
	logic [3:0]    nv_eff;

	logic [SW-1:0] depth_q;
	logic [3:0]    stk_q [0:STK-1];
	logic [3:0]    stk_rd_q;
	logic          stk_wr;
	logic [SW-1:0] stk_wr_addr;
	logic [3:0]    stk_wr_data;

	logic          open_q;
	logic          failed_q;
	logic [2:0]    var_q;
	logic [3:0]    val_q;
	logic          last_q;

	logic [6:0]    r_q;
	logic          valid_s1;
	logic          match_any_q;
	logic [CW-1:0] cnt_q;
	logic          pend_valid_q;
	logic [CW-1:0] pend_q;

	logic          strobe_q;
	logic [1:0]    kind_q;
	logic [2:0]    pvar_q;
	logic [2:0]    pval_q;
	logic          last_res_q;

	cell_ctl_t     ctl;
	cell_sel_t     sel [0:NV-1];
	logic [NV:0]   ok_chain;
	logic          kv_valid [0:NV-1];
	logic [2:0]    kv_val   [0:NV-1];
	logic [7:0]    pm       [0:NV-1];

	logic          accept;
	logic          usable;
	logic          known_set;
	logic          set_known;
	logic          match;
	logic          cand;
	logic          res_fire;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign nr_eff = (num_supports_q > 7'(NR)) ? 7'(NR) : num_supports_q;
	assign nv_eff = (num_vars_q > 4'(NV)) ? 4'(NV) : num_vars_q;

	// Configuration registers; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_supports_q <= 7'd0;
			num_vars_q     <= 4'd8;
			domain_sizes_q <= 24'hFF_FFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_SUPPORTS: num_supports_q <= cfg_data[6:0];
				CFG_NUM_VARS:     num_vars_q     <= cfg_data[3:0];
				CFG_DOMAIN_SIZES: domain_sizes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A pair can bind only a variable in use with a non-wildcard value.
	assign usable    = ({1'b0, var_q} < nv_eff) && !val_q[3];
	assign known_set = kv_valid[var_q];
	assign set_known = (state_q == ST_PAIR) && !failed_q && usable && !known_set;
	assign match     = valid_s1 && ok_chain[NV];
	assign cand      = pm[cnt_q[CW-1:3]][cnt_q[2:0]];

	// A result leaves on a clash, on a scan with no matching row, on each
	// prune that has a successor, and at the end of the prune walk.
	assign res_fire = ((state_q == ST_PAIR) && !failed_q && usable && known_set &&
			(kv_val[var_q] != val_q[2:0])) ||
		((state_q == ST_EVAL) && !match_any_q) ||
		((state_q == ST_EMIT) && cand && pend_valid_q) ||
		(state_q == ST_FIN);

	// Cell controls. Reads run while the scan counter is inside the table.
	always_comb begin
		ctl.wr_en    = accept && (mode == MODE_LOAD);
		ctl.wr_row   = row_index;
		ctl.wr_val   = value;
		ctl.rd_en    = (state_q == ST_SCAN) && (r_q < nr_eff);
		ctl.rd_row   = r_q[RW-1:0];
		ctl.clr_scan = (state_q == ST_PAIR) && !failed_q && last_q &&
			!(usable && known_set && (kv_val[var_q] != val_q[2:0]));
		ctl.upd      = match;
		ctl.set_val  = val_q[2:0];
		for (int i = 0; i < NV; i++) begin
			sel[i].wr  = (var_index == VW'(i));
			sel[i].set = set_known && (var_q == VW'(i));
			sel[i].clr = (state_q == ST_UNDO_CHK) && (stk_rd_q != MARKER) &&
				(stk_rd_q[VW-1:0] == VW'(i));
		end
	end

	assign ok_chain[0] = 1'b1;

	for (genvar g = 0; g < NV; g++) begin : g_cell
		tcp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sel        (sel[g]),
			.used       (4'(g) < nv_eff),
			.dsm1       (domain_sizes_q[3*g +: 3]),
			.ok_in      (ok_chain[g]),
			.ok_out     (ok_chain[g+1]),
			.kv_valid   (kv_valid[g]),
			.kv_val     (kv_val[g]),
			.prune_mask (pm[g])
		);
	end

	// Undo stack: a marker opens each literal, then one entry per bound
	// variable. Pushes onto a full stack are dropped.
	always_comb begin
		stk_wr      = 1'b0;
		stk_wr_addr = depth_q;
		stk_wr_data = MARKER;
		if (accept && (mode == MODE_ASSIGN) && !open_q) begin
			stk_wr = (depth_q < SW'(STK));
		end else if (set_known) begin
			stk_wr      = (depth_q < SW'(STK));
			stk_wr_data = {1'b0, var_q};
		end
	end

	always_ff @(posedge clk) begin
		if (stk_wr) begin
			stk_q[stk_wr_addr[$clog2(STK)-1:0]] <= stk_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_UNDO_RD) && (depth_q != '0)) begin
			stk_rd_q <= stk_q[$clog2(STK)'(depth_q - SW'(1))];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			var_q  <= var_index;
			val_q  <= value;
			last_q <= last_of_literal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			depth_q      <= '0;
			open_q       <= 1'b0;
			failed_q     <= 1'b0;
			r_q          <= '0;
			valid_s1     <= 1'b0;
			match_any_q  <= 1'b0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			strobe_q     <= 1'b0;
			kind_q       <= KIND_DONE;
			pvar_q       <= '0;
			pval_q       <= '0;
			last_res_q   <= 1'b0;
		end else begin
			strobe_q <= res_fire;
			valid_s1 <= ctl.rd_en;
			if (stk_wr) begin
				depth_q <= depth_q + SW'(1);
			end
			if (match) begin
				match_any_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_ASSIGN: begin
								if (!open_q) begin
									open_q   <= 1'b1;
									failed_q <= 1'b0;
								end
								state_q <= ST_PAIR;
							end
							MODE_UNDO: begin
								open_q   <= 1'b0;
								failed_q <= 1'b0;
								state_q  <= ST_UNDO_RD;
							end
							default: ;
						endcase
					end
				end
				ST_PAIR: begin
					state_q <= ST_IDLE;
					if (failed_q) begin
						if (last_q) begin
							open_q   <= 1'b0;
							failed_q <= 1'b0;
						end
					end else if (usable && known_set && (kv_val[var_q] != val_q[2:0])) begin
						kind_q     <= KIND_CONFLICT;
						pvar_q     <= '0;
						pval_q     <= '0;
						last_res_q <= 1'b1;
						if (last_q) begin
							open_q <= 1'b0;
						end else begin
							failed_q <= 1'b1;
						end
					end else if (last_q) begin
						open_q      <= 1'b0;
						r_q         <= '0;
						match_any_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (r_q < nr_eff) begin
						r_q <= r_q + 7'd1;
					end else if (!valid_s1) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!match_any_q) begin
						kind_q     <= KIND_CONFLICT;
						pvar_q     <= '0;
						pval_q     <= '0;
						last_res_q <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						cnt_q        <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Hold one prune back so the final one can carry last.
					if (cand) begin
						if (pend_valid_q) begin
							kind_q     <= KIND_PRUNE;
							pvar_q     <= pend_q[CW-1:3];
							pval_q     <= pend_q[2:0];
							last_res_q <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_q       <= cnt_q;
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == '1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					kind_q     <= pend_valid_q ? KIND_PRUNE : KIND_DONE;
					pvar_q     <= pend_valid_q ? pend_q[CW-1:3] : 3'd0;
					pval_q     <= pend_valid_q ? pend_q[2:0] : 3'd0;
					last_res_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_UNDO_RD: begin
					if (depth_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						depth_q <= depth_q - SW'(1);
						state_q <= ST_UNDO_CHK;
					end
				end
				ST_UNDO_CHK: begin
					state_q <= (stk_rd_q == MARKER) ? ST_IDLE : ST_UNDO_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign kind      = kind_q;
	assign prune_var = pvar_q;
	assign prune_val = pval_q;
	assign last      = last_res_q;

	`ASSERT_IMPLY(a_strobe_from_busy, clk, arst_n, strobe, $past(busy))
	`ASSERT_ALWAYS(a_depth_bound, clk, arst_n, depth_q <= SW'(STK))
	`ASSERT_IMPLY(a_conflict_is_last, clk, arst_n, strobe && (kind == KIND_CONFLICT), last)
	`ASSERT_IMPLY(a_scan_reads_idle, clk, arst_n, valid_s1, $past(state_q == ST_SCAN))

endmodule

@@ rtl/tcp_cell.sv @@
// ----------------------------------------------------------------------------
// tcp_cell
// One variable column: its support entries, known value and scan summary.
// ----------------------------------------------------------------------------
module tcp_cell
	import tcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  cell_sel_t  sel,
	input  logic       used,
	input  logic [2:0] dsm1,
	input  logic       ok_in,
	output logic       ok_out,
	output logic       kv_valid,
	output logic [2:0] kv_val,
	output logic [7:0] prune_mask
);

	logic [3:0] mem_q [0:NR-1];
	logic [3:0] rd_q;
	logic       kv_valid_q;
	logic [2:0] kv_val_q;
	logic [7:0] seen_q;
	logic       wild_q;
	logic       local_ok;
	logic [7:0] dom_mask;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && sel.wr) begin
			mem_q[ctl.wr_row] <= ctl.wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q <= mem_q[ctl.rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kv_valid_q <= 1'b0;
		end else if (sel.set) begin
			kv_valid_q <= 1'b1;
		end else if (sel.clr) begin
			kv_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel.set) begin
			kv_val_q <= ctl.set_val;
		end
	end

	// A wildcard entry always fits; a value must lie in the domain and agree
	// with the known value, if there is one.
	assign local_ok = !used || rd_q[3] ||
		((rd_q[2:0] <= dsm1) && (!kv_valid_q || (kv_val_q == rd_q[2:0])));
	assign ok_out = ok_in & local_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			wild_q <= 1'b0;
		end else if (ctl.clr_scan) begin
			seen_q <= '0;
			wild_q <= 1'b0;
		end else if (ctl.upd && used) begin
			if (rd_q[3]) begin
				wild_q <= 1'b1;
			end else begin
				seen_q[rd_q[2:0]] <= 1'b1;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			dom_mask[j] = (3'(j) <= dsm1);
		end
	end

	assign prune_mask = (used && !wild_q) ? (~seen_q & dom_mask) : 8'h00;
	assign kv_valid   = kv_valid_q;
	assign kv_val     = kv_val_q;

endmodule

@@ tb/table_constraint_propagator_checker.sv @@
// ----------------------------------------------------------------------------
// table_constraint_propagator_checker
// Watches the item, result and register channels of the propagator, predicts
// every result from its own copy of the support table and assignment state,
// and compares each result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module table_constraint_propagator_checker
	import tcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        mode,
	input  logic [5:0]        row_index,
	input  logic [2:0]        var_index,
	input  logic signed [3:0] value,
	input  logic              last_of_literal,
	input  logic              strobe,
	input  logic [1:0]        kind,
	input  logic [2:0]        prune_var,
	input  logic [2:0]        prune_val,
	input  logic              last,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	output int                fail_count,
	output int                outstanding
);

	typedef struct {
		logic [1:0] kind;
		logic [2:0] pvar;
		logic [2:0] pval;
		logic       fin;
	} prop_result_t;

	prop_result_t expected_q[$];

	logic [6:0]  rows_in_use;
	logic [3:0]  vars_in_use;
	logic [23:0] dom_bits;
	logic [3:0]  table_q[NR][NV];
	logic [3:0]  known_val[NV];
	bit          known_set[NV];
	logic [3:0]  trail[STK];
	int          trail_depth;
	bit          lit_open;
	bit          lit_failed;

	assign outstanding = expected_q.size();

	function automatic int eff_vars();
		return (vars_in_use > NV) ? NV : int'(vars_in_use);
	endfunction

	function automatic int eff_rows();
		return (rows_in_use > NR) ? NR : int'(rows_in_use);
	endfunction

	function automatic int dom_of(int v);
		return int'(dom_bits[3*v +: 3]) + 1;
	endfunction

	function automatic void add_result(logic [1:0] k, int pv, int pl, bit f);
		prop_result_t r;
		r.kind = k;
		r.pvar = pv[2:0];
		r.pval = pl[2:0];
		r.fin  = f;
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic void push_trail(logic [3:0] e);
		if (trail_depth < STK) begin
			trail[trail_depth] = e;
			trail_depth++;
		end
	endfunction

	// Support scan: rows agreeing with every known value take part, and each
	// variable free of wildcards loses the in-domain values none of them hold.
	function automatic void predict_scan();
		int nv;
		int hits;
		int n;
		bit ok;
		bit wild[NV];
		logic [7:0] seen[NV];
		logic [3:0] x;
		nv = eff_vars();
		hits = 0;
		n = 0;
		for (int v = 0; v < NV; v++) begin
			wild[v] = 0;
			seen[v] = '0;
		end
		for (int r = 0; r < eff_rows(); r++) begin
			ok = 1;
			for (int v = 0; v < nv; v++) begin
				x = table_q[r][v];
				if (!x[3]) begin
					if (int'(x) >= dom_of(v)) ok = 0;
					else if (known_set[v] && known_val[v] != x) ok = 0;
				end
			end
			if (ok) begin
				hits++;
				for (int v = 0; v < nv; v++) begin
					x = table_q[r][v];
					if (x[3]) wild[v] = 1;
					else seen[v][x[2:0]] = 1;
				end
			end
		end
		if (hits == 0) begin
			add_result(KIND_CONFLICT, 0, 0, 1);
			return;
		end
		for (int v = 0; v < nv; v++)
			if (!wild[v])
				for (int j = 0; j < dom_of(v); j++)
					if (!seen[v][j]) begin
						add_result(KIND_PRUNE, v, j, 0);
						n++;
					end
		if (n == 0) add_result(KIND_DONE, 0, 0, 1);
		else expected_q[$].fin = 1;
	endfunction

	function automatic void predict_item(logic [1:0] m, logic [5:0] row, logic [2:0] vr,
			logic [3:0] val, bit fin);
		logic [3:0] e;
		if (m == MODE_LOAD) begin
			table_q[row][vr] = val;
		end else if (m == MODE_UNDO) begin
			while (trail_depth > 0) begin
				trail_depth--;
				e = trail[trail_depth];
				if (e == MARKER) break;
				known_set[e[2:0]] = 0;
			end
			lit_open = 0;
			lit_failed = 0;
		end else if (m == MODE_ASSIGN) begin
			if (!lit_open) begin
				push_trail(MARKER);
				lit_open = 1;
				lit_failed = 0;
			end
			if (lit_failed) begin
				if (fin) begin
					lit_open = 0;
					lit_failed = 0;
				end
				return;
			end
			if (int'(vr) < eff_vars() && !val[3]) begin
				if (known_set[vr]) begin
					if (known_val[vr] != val) begin
						add_result(KIND_CONFLICT, 0, 0, 1);
						if (fin) lit_open = 0;
						else lit_failed = 1;
						return;
					end
				end else begin
					push_trail({1'b0, vr});
					known_set[vr] = 1;
					known_val[vr] = val;
				end
			end
			if (fin) begin
				lit_open = 0;
				predict_scan();
			end
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: result %s is %0d, %0d was predicted", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		prop_result_t w;
		if (!arst_n) begin
			fail_count = 0;
			rows_in_use = 0;
			vars_in_use = 8;
			dom_bits = 24'hFFFFFF;
			for (int v = 0; v < NV; v++) known_set[v] = 0;
			trail_depth = 0;
			lit_open = 0;
			lit_failed = 0;
			expected_q.delete();
		end else begin
			if (strobe) begin
				if (expected_q.size() == 0) begin
					report_mismatch("count beyond predictions, kind", kind, -1);
				end else begin
					w = expected_q.pop_front();
					if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
					if (prune_var !== w.pvar) report_mismatch("prune_var", prune_var, w.pvar);
					if (prune_val !== w.pval) report_mismatch("prune_val", prune_val, w.pval);
					if (last !== w.fin) report_mismatch("last", last, w.fin);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NUM_SUPPORTS: rows_in_use = cfg_data[6:0];
					CFG_NUM_VARS:     vars_in_use = cfg_data[3:0];
					CFG_DOMAIN_SIZES: dom_bits = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				predict_item(mode, row_index, var_index, value, last_of_literal);
		end
	end

endmodule

@@ tb/table_constraint_propagator_top_tb.sv @@
// ----------------------------------------------------------------------------
// table_constraint_propagator_top_tb
// Drives load, assign and undo items into the propagator under changing
// register settings, with random idle gaps, while the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module table_constraint_propagator_top_tb;
	import tcp_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE      = 300;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              start = 0;
	logic              busy;
	logic [1:0]        mode = MODE_LOAD;
	logic [5:0]        row_index = '0;
	logic [2:0]        var_index = '0;
	logic signed [3:0] value = '0;
	logic              last_of_literal = 0;
	logic              strobe;
	logic [1:0]        kind;
	logic [2:0]        prune_var;
	logic [2:0]        prune_val;
	logic              last;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [23:0]       cfg_data = '0;

	int fail_count;
	int outstanding;
	int quiet_cycles;
	bit no_gaps;

	// Mirror of the loaded table, used only to steer assignments toward
	// values that real rows hold, so that scans find matches.
	logic signed [3:0] loaded[NR][NV];
	int cur_vars;

	always #5 clk = ~clk;

	table_constraint_propagator_top DUT (.*);

	table_constraint_propagator_checker checker_i (.*);

	// The watchdog restarts whenever any of the three channels moves.
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// One item: an optional idle burst, then start held until busy is low at
	// an edge. Start stays high between back-to-back items.
	task automatic send_item(logic [1:0] m, int row, int vr, int val, bit fin);
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1;
		mode <= m;
		row_index <= row[5:0];
		var_index <= vr[2:0];
		value <= val[3:0];
		last_of_literal <= fin;
		do @(posedge clk); while (busy);
		if (m == MODE_LOAD) loaded[row[5:0]][vr[2:0]] = val[3:0];
	endtask

	// Registers change only with the block idle: every predicted result in,
	// and time for an undo or a load without results to finish.
	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		start <= 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == CFG_NUM_VARS) cur_vars = (data[3:0] > NV) ? NV : int'(data[3:0]);
	endtask

	// A literal of one to three pairs. Most values come from a loaded row so
	// that some rows stay in play; the rest are arbitrary, wildcards included.
	task automatic send_literal();
		int n;
		int r;
		int vr;
		int val;
		n = $urandom_range(1, 3);
		r = $urandom_range(0, 7);
		for (int i = 0; i < n; i++) begin
			vr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
				: $urandom_range(0, (cur_vars > 0 ? cur_vars : 1) - 1);
			case ($urandom_range(0, 9))
				0:       val = $urandom_range(0, 15);
				1, 2:    val = $urandom_range(0, 7);
				default: val = loaded[r][vr];
			endcase
			send_item(MODE_ASSIGN, 0, vr, val, i == n - 1);
		end
	endtask

	initial begin
		int val;
		int choice;
		cur_vars = NV;
		no_gaps = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed part. With no rows in use every scan is a conflict.
		write_reg(CFG_NUM_SUPPORTS, 0);
		send_item(MODE_ASSIGN, 0, 0, 7, 1);
		send_item(MODE_UNDO, 0, 0, 0, 0);
		send_item(MODE_UNDO, 0, 0, 0, 0);                 // undo with empty stack
		send_item(2'd3, 0, 0, 0, 0);                      // unused mode
		send_item(MODE_ASSIGN, 0, 3, 2, 0);
		send_item(MODE_ASSIGN, 0, 3, 5, 0);               // clash with known value
		send_item(MODE_ASSIGN, 0, 4, 1, 0);               // ignored after conflict
		send_item(MODE_ASSIGN, 0, 5, 1, 1);               // closes the literal
		send_item(MODE_ASSIGN, 0, 3, 2, 1);               // agrees with known value
		send_item(MODE_ASSIGN, 0, 1, -1, 1);              // negative value is unusable
		send_item(MODE_UNDO, 0, 0, 0, 0);
		send_item(MODE_UNDO, 0, 0, 0, 0);
		send_item(MODE_UNDO, 0, 0, 0, 0);

		// Fill the first two columns of every row and all columns of the
		// first eight rows. Every later setting keeps its scans inside this
		// loaded region, so no scan reads an unloaded entry.
		for (int r = 0; r < NR; r++)
			for (int v = 0; v < NV; v++) begin
				if (v >= 2 && r >= 8) continue;
				if (r == 0) val = v - 1;
				else if (r == NR - 1) val = 7;
				else val = $urandom_range(0, 8) - 1;
				send_item(MODE_LOAD, r, v, val, 0);
			end

		write_reg(CFG_NUM_SUPPORTS, 8);
		write_reg(CFG_NUM_VARS, 15);                      // counts as eight
		send_item(MODE_ASSIGN, 0, 0, 0, 1);
		send_item(MODE_ASSIGN, 0, 7, 7, 1);
		write_reg(CFG_NUM_VARS, 2);
		write_reg(CFG_NUM_SUPPORTS, 127);                 // counts as all rows
		send_item(MODE_ASSIGN, 0, 5, 3, 1);               // variable beyond those used
		send_item(MODE_UNDO, 0, 0, 0, 0);
		write_reg(CFG_NUM_VARS, 0);
		send_item(MODE_ASSIGN, 0, 0, 1, 1);

		// Random part: one register setting per phase, the first ones at
		// the extremes, the last phase without idle gaps.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_NUM_SUPPORTS, 64);
					write_reg(CFG_NUM_VARS, 2);
					write_reg(CFG_DOMAIN_SIZES, 24'hFFFFFF);
				end
				1: begin
					write_reg(CFG_NUM_SUPPORTS, 1);
					write_reg(CFG_NUM_VARS, 1);
					write_reg(CFG_DOMAIN_SIZES, 24'h000000);
				end
				8: begin
					write_reg(CFG_NUM_SUPPORTS, 0);
				end
				default: begin
					write_reg(CFG_NUM_SUPPORTS, $urandom_range(1, 8));
					write_reg(CFG_NUM_VARS, $urandom_range(1, 8));
					write_reg(CFG_DOMAIN_SIZES, $urandom_range(0, 24'hFFFFFF));
				end
			endcase
			no_gaps = (ph == 9);
			if (ph == 8) begin
				// Single-pair literals with no undo between them overflow
				// the undo stack.
				for (int i = 0; i < STK + 3; i++)
					send_item(MODE_ASSIGN, 0, 0, 0, 1);
			end else begin
				for (int i = 0; i < 3; i++) begin
					choice = $urandom_range(0, 19);
					if (choice < 3) send_item(MODE_UNDO, 0, 0, 0, 0);
					else if (choice == 3) send_item($urandom_range(0, 1) ? 2'd3 : MODE_UNDO,
						$urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 15),
						$urandom_range(0, 1));
					else if (choice == 4) send_item(MODE_LOAD, $urandom_range(0, 63),
						$urandom_range(0, 7), $urandom_range(0, 8) - 1,
						$urandom_range(0, 1));
					else send_literal();
				end
			end
			send_item(MODE_UNDO, 0, 0, 0, 0);
		end

		start <= 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
